### src/hce_pkg.sv
package hce_pkg;

	localparam int MAX_POINTS = 64;
	localparam int PTR_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = PTR_W + 1;
	localparam int FRAC_BITS  = 16;
	localparam int WBITS      = 30;
	localparam int DIV_SHIFT  = WBITS - FRAC_BITS;
	localparam int ENTRY_W    = 128;
	localparam int CFG_W      = 32;

	localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_POINTS);

	localparam logic KIND_EVAL  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	localparam logic REG_POINT_COUNT   = 1'b0;
	localparam logic REG_DEFAULT_VALUE = 1'b1;

	typedef struct packed {
		logic                     kind;
		logic [31:0]              query_time;
		logic [PTR_W-1:0]         point_index;
		logic [31:0]              point_time;
		logic signed [31:0]       point_value;
		logic signed [31:0]       left_slope;
		logic signed [31:0]       right_slope;
	} item_t;

	typedef struct packed {
		logic signed [31:0] curve_value;
		logic signed [31:0] curve_slope;
		logic [CNT_W-1:0]   segment;
	} result_t;

	typedef struct packed {
		logic        start;
		logic [31:0] divisor;
		logic [31:0] rem_init;
		logic        q_init;
		logic [48:0] feed;
		logic [5:0]  steps;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [49:0] quot;
	} div_rsp_t;

	typedef enum logic [4:0] {
		S_IDLE, S_HL, S_HR, S_HN, S_HD, S_F0, S_F0W, S_F1W, S_BS, S_BSW,
		S_FA, S_FB, S_FC, S_TDIV, S_MUL, S_MWAIT, S_SDIV, S_LIN, S_LWAIT, S_FIN
	} state_t;

	typedef enum logic [4:0] {
		M_TT, M_SS, M_TS, M_H00, M_A, M_B, M_Y0, M_Y1, M_D0A, M_D1B,
		M_W0, M_W1, M_D0W, M_D1W, M_DYG, M_LIN, M_NONE
	} mstep_t;

endpackage

### src/hce_ram.sv
module hce_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/hce_div.sv
// Restoring divider, one quotient bit per cycle; remainder kept below the divisor.
module hce_div (
	input  logic              clk,
	input  logic              arst_n,
	input  hce_pkg::div_req_t req,
	output hce_pkg::div_rsp_t rsp
);

	logic [31:0] div_q;
	logic [31:0] rem_q;
	logic [49:0] quot_q;
	logic [48:0] feed_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic [32:0] diff;
	logic        ge;

	assign trial = {rem_q, feed_q[48]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q  <= req.divisor;
			rem_q  <= req.rem_init;
			quot_q <= {49'd0, req.q_init};
			feed_q <= req.feed;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[31:0] : trial[31:0];
			quot_q <= {quot_q[48:0], ge};
			feed_q <= {feed_q[47:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

### src/hermite_curve_evaluator.sv
// Cubic Hermite curve evaluator over a table of up to 64 Q16.16 control points
// (time, value, left slope, right slope) held in one 128-bit wide synchronous
// RAM. A write stores one point in the cycle it is accepted. An evaluate
// transaction finds the segment (cached segment, then the next one, then the
// first and last, then a binary search over the RAM), fetches both end points,
// runs the normalized position t = u/h through the shared serial divider
// (30 steps), evaluates the basis terms on one registered 34x34 multiplier
// (15 products), and divides the slope term on the same divider (49 steps).
// An evaluate is longest when it needs a full binary search, and those two
// divisions take most of its time. Points past the last one and degenerate
// segments take a short linear path; an empty curve skips the search and the
// arithmetic. One transaction is worked on at a time; the result register
// lets the next one be accepted while a result waits. Results saturate to
// 32 bits. The table comes out of reset unwritten and needs no clearing pass.
module hermite_curve_evaluator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic                          cfg_index,
	input  logic [hce_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  hce_pkg::item_t                item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output hce_pkg::result_t              result
);

	localparam int CW = hce_pkg::CNT_W;
	localparam int PW = hce_pkg::PTR_W;

	localparam logic [30:0]        WONE   = 31'(1) << hce_pkg::WBITS;
	localparam logic signed [33:0] WONE34 = 34'sd1 <<< hce_pkg::WBITS;
	localparam logic signed [33:0] WTWO34 = 34'sd1 <<< (hce_pkg::WBITS + 1);

	function automatic logic [31:0] sat32(input logic signed [63:0] v);
		logic [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	hce_pkg::state_t state_q, state_d;
	hce_pkg::mstep_t step_q, pstep_q, mul_step;

	// configuration
	logic [CW-1:0]      count_q;
	logic signed [31:0] default_q;

	// search
	logic [31:0]   x_q;
	logic [CW-1:0] n_q, last_q, seg_q, lo_q, hi_q, mid_q;
	logic          hint_q;
	logic [31:0]   tl_q, tr_q;

	// segment end points
	logic [31:0]        x0_q, h_q, u_q;
	logic signed [31:0] y0_q, d0_q, y1_q, d1_q;

	// arithmetic
	logic [30:0]        t_q, t2_q, s2_q, g_q, h00_q;
	logic [31:0]        a_q, b_q;
	logic signed [63:0] acc_q, val_q, sl_q;
	logic signed [33:0] w0_q, w1_q;
	logic signed [67:0] p_q;
	logic               neg_q;

	logic           out_valid_q;
	hce_pkg::result_t out_q;

	// RAM
	logic                          ram_we;
	logic [PW-1:0]                 ram_raddr;
	logic [hce_pkg::ENTRY_W-1:0]   ram_rdata;
	logic [31:0]                   r_time;
	logic signed [31:0]            r_value, r_left, r_right;

	hce_pkg::div_req_t div_req;
	hce_pkg::div_rsp_t div_rsp;

	// combinational helpers
	logic          accept, do_eval;
	logic [CW-1:0] ncap, last_m1, last_p1, n_m1, seg_m1, mid_w;
	logic          in_a, in_b, herm;
	logic [31:0]   h_w, u_raw, u_w;
	logic [30:0]   s_w;
	logic signed [33:0] t3, opa, opb;
	logic signed [67:0] p_sh30, p_sh16, p_sh14;
	logic [63:0]   six_ts;
	logic [48:0]   mag;
	logic [63:0]   qext, sdiv;

	assign accept  = item_valid && !item_stall;
	assign do_eval = accept && (item.kind == hce_pkg::KIND_EVAL);
	assign ram_we  = accept && (item.kind == hce_pkg::KIND_WRITE);

	assign ncap    = (count_q > hce_pkg::COUNT_MAX) ? hce_pkg::COUNT_MAX : count_q;
	assign last_m1 = last_q - CW'(1);
	assign last_p1 = last_q + CW'(1);
	assign n_m1    = n_q - CW'(1);
	assign seg_m1  = seg_q - CW'(1);
	assign mid_w   = CW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);

	assign r_time  = ram_rdata[127:96];
	assign r_value = ram_rdata[95:64];
	assign r_left  = ram_rdata[63:32];
	assign r_right = ram_rdata[31:0];

	hce_ram #(
		.WIDTH(hce_pkg::ENTRY_W),
		.DEPTH(hce_pkg::MAX_POINTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(item.point_index),
		.wdata({item.point_time, item.point_value, item.left_slope, item.right_slope}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	hce_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// cached segment and its successor, tested against the three fetched times
	assign in_a = ((last_q == '0) || (x_q >= tl_q)) && ((last_q >= n_q) || (x_q < tr_q));
	assign in_b = (last_q < n_q) && (x_q >= tr_q) && ((last_p1 >= n_q) || (x_q < r_time));

	// right end point arrives in S_FC
	assign herm  = (seg_q < n_q) && (r_time > x0_q);
	assign h_w   = r_time - x0_q;
	assign u_raw = (x_q < x0_q) ? 32'd0 : (x_q - x0_q);
	assign u_w   = (u_raw > h_w) ? h_w : u_raw;

	assign s_w    = WONE - t_q;
	assign t3     = $signed({2'b00, t_q, 1'b0}) + $signed({3'b000, t_q});
	assign p_sh30 = p_q >>> hce_pkg::WBITS;
	assign p_sh16 = p_q >>> hce_pkg::FRAC_BITS;
	assign p_sh14 = p_q >>> hce_pkg::DIV_SHIFT;
	assign six_ts = {p_q[61:0], 2'b00} + {p_q[62:0], 1'b0};
	assign mag    = p_q[67] ? ~p_sh14[48:0] : p_sh14[48:0];
	assign qext   = {14'd0, div_rsp.quot};
	assign sdiv   = neg_q ? ~qext : qext;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hce_pkg::S_IDLE: begin
				if (do_eval) begin
					if (ncap == '0) begin
						state_d = hce_pkg::S_FIN;
					end else if (hint_q && (last_q <= ncap)) begin
						state_d = hce_pkg::S_HL;
					end else begin
						state_d = hce_pkg::S_F0;
					end
				end
			end
			hce_pkg::S_HL:  state_d = hce_pkg::S_HR;
			hce_pkg::S_HR:  state_d = hce_pkg::S_HN;
			hce_pkg::S_HN:  state_d = hce_pkg::S_HD;
			hce_pkg::S_HD:  state_d = (in_a || in_b) ? hce_pkg::S_FA : hce_pkg::S_F0;
			hce_pkg::S_F0:  state_d = hce_pkg::S_F0W;
			hce_pkg::S_F0W: state_d = (x_q < r_time) ? hce_pkg::S_FA : hce_pkg::S_F1W;
			hce_pkg::S_F1W: state_d = (x_q >= r_time) ? hce_pkg::S_FA : hce_pkg::S_BS;
			hce_pkg::S_BS:  state_d = (lo_q < hi_q) ? hce_pkg::S_BSW : hce_pkg::S_FA;
			hce_pkg::S_BSW: state_d = hce_pkg::S_BS;
			hce_pkg::S_FA:  state_d = hce_pkg::S_FB;
			hce_pkg::S_FB:  state_d = hce_pkg::S_FC;
			hce_pkg::S_FC:  state_d = herm ? hce_pkg::S_TDIV : hce_pkg::S_LIN;
			hce_pkg::S_TDIV: begin
				if (div_rsp.done) begin
					state_d = hce_pkg::S_MUL;
				end
			end
			hce_pkg::S_MUL: begin
				if (step_q == hce_pkg::M_DYG) begin
					state_d = hce_pkg::S_MWAIT;
				end
			end
			hce_pkg::S_MWAIT: state_d = hce_pkg::S_SDIV;
			hce_pkg::S_SDIV: begin
				if (div_rsp.done) begin
					state_d = hce_pkg::S_FIN;
				end
			end
			hce_pkg::S_LIN:   state_d = hce_pkg::S_LWAIT;
			hce_pkg::S_LWAIT: state_d = hce_pkg::S_FIN;
			hce_pkg::S_FIN: begin
				if (!out_valid_q || !result_stall) begin
					state_d = hce_pkg::S_IDLE;
				end
			end
			default: state_d = hce_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer: RAM address, multiplier step, divider request, item stall
	always_comb begin
		ram_raddr       = '0;
		mul_step        = hce_pkg::M_NONE;
		div_req.start   = 1'b0;
		div_req.divisor = h_w;
		div_req.rem_init = (u_w >= h_w) ? 32'd0 : u_w;
		div_req.q_init  = (u_w >= h_w);
		div_req.feed    = '0;
		div_req.steps   = 6'(hce_pkg::WBITS);
		item_stall      = (state_q != hce_pkg::S_IDLE);
		unique case (state_q)
			hce_pkg::S_HL:  ram_raddr = last_m1[PW-1:0];
			hce_pkg::S_HR:  ram_raddr = last_q[PW-1:0];
			hce_pkg::S_HN:  ram_raddr = last_p1[PW-1:0];
			hce_pkg::S_F0:  ram_raddr = '0;
			hce_pkg::S_F0W: ram_raddr = n_m1[PW-1:0];
			hce_pkg::S_BS:  ram_raddr = mid_w[PW-1:0];
			hce_pkg::S_FA:  ram_raddr = seg_m1[PW-1:0];
			hce_pkg::S_FB:  ram_raddr = seg_q[PW-1:0];
			hce_pkg::S_FC:  div_req.start = herm;
			hce_pkg::S_MUL: mul_step = step_q;
			hce_pkg::S_LIN: mul_step = hce_pkg::M_LIN;
			hce_pkg::S_MWAIT: begin
				div_req.start    = 1'b1;
				div_req.divisor  = h_q;
				div_req.rem_init = '0;
				div_req.q_init   = 1'b0;
				div_req.feed     = mag;
				div_req.steps    = 6'd49;
			end
			default: ;
		endcase
	end

	// multiplier operands
	always_comb begin
		opa = '0;
		opb = '0;
		case (mul_step)
			hce_pkg::M_TT:  begin opa = $signed({3'b0, t_q});  opb = $signed({3'b0, t_q});  end
			hce_pkg::M_SS:  begin opa = $signed({3'b0, s_w});  opb = $signed({3'b0, s_w});  end
			hce_pkg::M_TS:  begin opa = $signed({3'b0, t_q});  opb = $signed({3'b0, s_w});  end
			hce_pkg::M_H00: begin
				opa = WONE34 + $signed({2'b0, t_q, 1'b0});
				opb = $signed({3'b0, s2_q});
			end
			hce_pkg::M_A:   begin opa = $signed({2'b0, u_q});  opb = $signed({3'b0, s2_q}); end
			hce_pkg::M_B:   begin
				opa = $signed({2'b0, h_q - u_q});
				opb = $signed({3'b0, t2_q});
			end
			hce_pkg::M_Y0:  begin opa = 34'(y0_q); opb = $signed({3'b0, h00_q}); end
			hce_pkg::M_Y1:  begin opa = 34'(y1_q); opb = $signed({3'b0, WONE - h00_q}); end
			hce_pkg::M_D0A: begin opa = 34'(d0_q); opb = $signed({2'b0, a_q}); end
			hce_pkg::M_D1B: begin opa = 34'(d1_q); opb = $signed({2'b0, b_q}); end
			hce_pkg::M_W0:  begin opa = $signed({3'b0, s_w}); opb = WONE34 - t3; end
			hce_pkg::M_W1:  begin opa = $signed({3'b0, t_q}); opb = t3 - WTWO34; end
			hce_pkg::M_D0W: begin opa = 34'(d0_q); opb = w0_q; end
			hce_pkg::M_D1W: begin opa = 34'(d1_q); opb = w1_q; end
			hce_pkg::M_DYG: begin opa = 34'(y1_q) - 34'(y0_q); opb = $signed({3'b0, g_q}); end
			hce_pkg::M_LIN: begin
				opa = 34'(d0_q);
				opb = $signed({2'b0, x_q}) - $signed({2'b0, x0_q});
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hce_pkg::S_IDLE;
			step_q      <= hce_pkg::M_TT;
			pstep_q     <= hce_pkg::M_NONE;
			count_q     <= '0;
			default_q   <= '0;
			last_q      <= '0;
			hint_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pstep_q <= mul_step;
			if (cfg_write) begin
				if (cfg_index == hce_pkg::REG_POINT_COUNT) begin
					count_q <= cfg_data[CW-1:0];
				end else begin
					default_q <= $signed(cfg_data);
				end
			end
			if (state_q == hce_pkg::S_TDIV) begin
				step_q <= hce_pkg::M_TT;
			end else if (state_q == hce_pkg::S_MUL) begin
				step_q <= hce_pkg::mstep_t'(step_q + 5'd1);
			end
			// update the cached segment
			case (state_q)
				hce_pkg::S_HD: begin
					if (!in_a && in_b) begin
						last_q <= last_p1;
					end
				end
				hce_pkg::S_F0W: begin
					if (x_q < r_time) begin
						last_q <= '0;
						hint_q <= 1'b1;
					end
				end
				hce_pkg::S_F1W: begin
					if (x_q >= r_time) begin
						last_q <= n_q;
						hint_q <= 1'b1;
					end
				end
				hce_pkg::S_BS: begin
					if (lo_q >= hi_q) begin
						last_q <= lo_q;
						hint_q <= 1'b1;
					end
				end
				default: ;
			endcase
			// result register: drop on take, reload from the finish state
			if (result_valid && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			if ((state_q == hce_pkg::S_FIN) && (!out_valid_q || !result_stall)) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		p_q <= opa * opb;

		case (state_q)
			hce_pkg::S_IDLE: begin
				x_q   <= item.query_time;
				n_q   <= ncap;
				seg_q <= '0;
				val_q <= 64'(default_q);
				sl_q  <= '0;
			end
			hce_pkg::S_HR: tl_q <= r_time;
			hce_pkg::S_HN: tr_q <= r_time;
			hce_pkg::S_HD: seg_q <= in_a ? last_q : last_p1;
			hce_pkg::S_F0W: seg_q <= '0;
			hce_pkg::S_F1W: begin
				seg_q <= n_q;
				lo_q  <= '0;
				hi_q  <= n_q;
			end
			hce_pkg::S_BS: begin
				mid_q <= mid_w;
				seg_q <= lo_q;
			end
			hce_pkg::S_BSW: begin
				if (x_q < r_time) begin
					hi_q <= mid_q;
				end else begin
					lo_q <= mid_q + CW'(1);
				end
			end
			hce_pkg::S_FB: begin
				if (seg_q != '0) begin
					x0_q <= r_time;
					y0_q <= r_value;
					d0_q <= r_right;
				end else begin
					x0_q <= '0;
					y0_q <= default_q;
					d0_q <= '0;
				end
			end
			hce_pkg::S_FC: begin
				y1_q <= r_value;
				d1_q <= r_left;
				h_q  <= h_w;
				u_q  <= u_w;
			end
			hce_pkg::S_TDIV: t_q <= div_rsp.quot[30:0];
			hce_pkg::S_SDIV: begin
				if (div_rsp.done) begin
					sl_q <= sl_q + $signed(sdiv);
				end
			end
			default: ;
		endcase

		// consume the product of the previous step
		case (pstep_q)
			hce_pkg::M_TT:  t2_q  <= p_q[60:30];
			hce_pkg::M_SS:  s2_q  <= p_q[60:30];
			hce_pkg::M_TS:  g_q   <= six_ts[60:30];
			hce_pkg::M_H00: h00_q <= p_q[60:30];
			hce_pkg::M_A:   a_q   <= p_q[61:30];
			hce_pkg::M_B:   b_q   <= p_q[61:30];
			hce_pkg::M_Y0:  acc_q <= p_q[63:0];
			hce_pkg::M_Y1:  acc_q <= acc_q + $signed(p_q[63:0]);
			hce_pkg::M_D0A: val_q <= (acc_q >>> hce_pkg::WBITS) + $signed(p_sh16[63:0]);
			hce_pkg::M_D1B: val_q <= val_q - $signed(p_sh16[63:0]);
			hce_pkg::M_W0:  w0_q  <= p_sh30[33:0];
			hce_pkg::M_W1:  w1_q  <= p_sh30[33:0];
			hce_pkg::M_D0W: sl_q  <= p_sh30[63:0];
			hce_pkg::M_D1W: sl_q  <= sl_q + $signed(p_sh30[63:0]);
			hce_pkg::M_DYG: neg_q <= p_q[67];
			hce_pkg::M_LIN: begin
				val_q <= 64'(y0_q) + $signed(p_sh16[63:0]);
				sl_q  <= 64'(d0_q);
			end
			default: ;
		endcase

		if ((state_q == hce_pkg::S_FIN) && (!out_valid_q || !result_stall)) begin
			out_q.curve_value <= sat32(val_q);
			out_q.curve_slope <= sat32(sl_q);
			out_q.segment     <= seg_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
